// ===== rtl/salc_pkg.sv =====
// Shared constants and types of the set-associative LRU cache model.
package salc_pkg;

    localparam int LINE_SIZE  = 64;
    localparam int NUM_SETS   = 8;
    localparam int NUM_WAYS   = 4;
    localparam int ADDR_BITS  = 32;

    localparam int IN_BITS      = 32;
    localparam int OUT_SET_BITS = 3;
    localparam int MISS_BITS    = 32;

    localparam int EFF_BITS    = (ADDR_BITS < IN_BITS) ? ADDR_BITS : IN_BITS;
    localparam int OFFSET_BITS = $clog2(LINE_SIZE);
    localparam int SET_BITS    = $clog2(NUM_SETS);
    localparam int SET_W       = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_RAW     = EFF_BITS - OFFSET_BITS - SET_BITS;
    localparam int TAG_BITS    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WAY_W       = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int NUM_SLOTS   = NUM_SETS * NUM_WAYS;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [IN_BITS-1:0] IN_MASK =
        (ADDR_BITS >= IN_BITS) ? {IN_BITS{1'b1}}
                               : IN_BITS'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [SET_W-1:0]   SET_MASK = SET_W'(NUM_SETS - 1);
    localparam logic [WAY_W-1:0]   LAST_POS = WAY_W'(NUM_WAYS - 1);
    localparam logic [MISS_BITS-1:0] MISS_MAX = {MISS_BITS{1'b1}};

    typedef logic [WAY_W-1:0]    t_way;
    typedef logic [SET_W-1:0]    t_set;
    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [SLOT_W-1:0]   t_slot;

endpackage

// ===== rtl/salc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/set_assoc_lru_cache_model_unit.sv =====
// Top level of the set-associative LRU cache model with miss counting.
//
// Input channel: i_valid / o_ready carry one byte address per item.
// Output channel: o_valid / i_ready carry hit, set index and the running
// miss count for that access, one result item per input item.
// A small sequencer walks the set's recency order from most to least
// recent, reading one tag per probe from the tag RAM and checking it with
// a single comparator; each probe passes a RAM read state and a compare state.
// A hit ends the walk at its recency position, a miss probes all NUM_WAYS
// positions; either way an update state and an emit state follow.
// The next item is taken in the cycle after the result is loaded.
// o_ready is high only while the sequencer is idle; a new item may enter
// while the previous result still waits in the output register.
// If the receiver stalls, the finished result is held and a following
// item completes its lookup and then waits until the output is free.
// Reset (synchronous, active low) clears all valid bits, restores the
// identity recency order in every set and zeroes the miss counter.
module set_assoc_lru_cache_model_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_byte_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [2:0]  o_set_index,
    output logic [31:0] o_miss_count
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]           r_state;
    salc_pkg::t_set       r_set;
    salc_pkg::t_tag       r_tag;
    salc_pkg::t_way       r_pos;
    logic                 r_hit;
    logic [salc_pkg::MISS_BITS-1:0] r_miss;
    logic [salc_pkg::NUM_SLOTS-1:0] r_valid_bits;
    salc_pkg::t_way       r_order [salc_pkg::NUM_SETS][salc_pkg::NUM_WAYS];

    logic                 r_o_valid;
    logic                 r_o_hit;
    logic [2:0]           r_o_set;
    logic [31:0]          r_o_miss;

    logic [salc_pkg::IN_BITS-1:0] addr_masked;
    logic [salc_pkg::IN_BITS-1:0] line_num;
    salc_pkg::t_set       in_set;
    salc_pkg::t_tag       in_tag;
    salc_pkg::t_way       cur_way;
    salc_pkg::t_slot      cur_slot;
    salc_pkg::t_tag       ram_rdata;
    logic                 ram_we;
    logic                 tag_match;
    logic                 out_free;
    logic                 emit_fire;
    salc_pkg::t_way       n_row [salc_pkg::NUM_WAYS];

    // split the address into set and tag
    assign addr_masked = i_byte_address & salc_pkg::IN_MASK;
    assign line_num    = addr_masked >> salc_pkg::OFFSET_BITS;
    assign in_set      = salc_pkg::SET_W'(line_num) & salc_pkg::SET_MASK;
    assign in_tag      = salc_pkg::TAG_BITS'(line_num >> salc_pkg::SET_BITS);

    assign cur_way  = r_order[r_set][r_pos];
    assign cur_slot = salc_pkg::SLOT_W'(salc_pkg::SLOT_W'(r_set)
                      * salc_pkg::SLOT_W'(salc_pkg::NUM_WAYS))
                      + salc_pkg::SLOT_W'(cur_way);

    assign tag_match = r_valid_bits[cur_slot] && (ram_rdata == r_tag);
    assign ram_we    = (r_state == S_UPDATE) && !r_hit;
    assign out_free  = !r_o_valid || i_ready;
    assign emit_fire = (r_state == S_EMIT) && out_free;

    // move the way at r_pos to the front, shift the more recent ones back
    always_comb begin
        for (int p = 0; p < salc_pkg::NUM_WAYS; p++) begin
            if (p == 0) begin
                n_row[p] = r_order[r_set][r_pos];
            end else if (salc_pkg::WAY_W'(p) <= r_pos) begin
                n_row[p] = r_order[r_set][p-1];
            end else begin
                n_row[p] = r_order[r_set][p];
            end
        end
    end

    salc_ram #(
        .WIDTH (salc_pkg::TAG_BITS),
        .DEPTH (salc_pkg::NUM_SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur_slot),
        .i_wdata (r_tag),
        .i_raddr (cur_slot),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_hit        <= 1'b0;
            r_miss       <= '0;
            r_valid_bits <= '0;
            r_o_valid    <= 1'b0;
            for (int s = 0; s < salc_pkg::NUM_SETS; s++) begin
                for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
                    r_order[s][w] <= salc_pkg::WAY_W'(w);
                end
            end
        end else begin
            // drop the taken result unless a new one is loaded this cycle
            if (r_o_valid && i_ready && !emit_fire) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_set   <= in_set;
                        r_tag   <= in_tag;
                        r_pos   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (tag_match) begin
                        r_hit   <= 1'b1;
                        r_state <= S_UPDATE;
                    end else if (r_pos == salc_pkg::LAST_POS) begin
                        r_hit   <= 1'b0;
                        r_state <= S_UPDATE;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_UPDATE: begin
                    // on a miss, r_pos is the least recent position
                    if (!r_hit) begin
                        r_valid_bits[cur_slot] <= 1'b1;
                        if (r_miss != salc_pkg::MISS_MAX) begin
                            r_miss <= r_miss + 1'b1;
                        end
                    end
                    for (int p = 0; p < salc_pkg::NUM_WAYS; p++) begin
                        r_order[r_set][p] <= n_row[p];
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_hit   <= r_hit;
                        r_o_set   <= 3'(r_set);
                        r_o_miss  <= r_miss;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_hit        = r_o_hit;
    assign o_set_index  = r_o_set;
    assign o_miss_count = r_o_miss;

endmodule
